@@ sv/tsd_pkg.sv @@
// package: codes, result type and crc helper for the scratchpad decoder
package tsd_pkg;

	localparam int BYTE_W = 8;
	localparam int TEMP_W = 16;
	localparam int POS_W  = 4;
	localparam int CFG_INDEX_W = 4;

	localparam logic [POS_W-1:0] FIRST_POS = 4'd0;
	localparam logic [POS_W-1:0] CRC_POS   = 4'd8;
	localparam logic [POS_W-1:0] DONE_POS  = 4'd9;

	localparam logic [CFG_INDEX_W-1:0] CFG_LOW_LIMIT  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_LIMIT = 4'd1;

	localparam logic signed [TEMP_W-1:0] LOW_LIMIT_RESET  = -16'sd880;
	localparam logic signed [TEMP_W-1:0] HIGH_LIMIT_RESET = 16'sd1360;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

	localparam logic [BYTE_W-1:0] FAM_9BIT  = 8'h10;
	localparam logic [BYTE_W-1:0] FAM_12BIT = 8'h28;
	localparam logic [BYTE_W-1:0] FAM_ALT   = 8'h22;

	localparam logic [BYTE_W-1:0] COUNT_PER_C = 8'h10;
	localparam logic [TEMP_W-1:0] HALF_MASK   = 16'hFFF0;
	localparam logic [TEMP_W-1:0] COUNT_BIAS  = 16'd12;

	localparam logic [BYTE_W-1:0] RES_FIELD = 8'h60;
	localparam logic [BYTE_W-1:0] RES_9BIT  = 8'h00;
	localparam logic [BYTE_W-1:0] RES_10BIT = 8'h20;
	localparam logic [BYTE_W-1:0] RES_11BIT = 8'h40;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_CRC = 2'd1,
		ST_RANGE   = 2'd2,
		ST_FAMILY  = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		status_t                  status;
	} result_t;

	// reflected crc-8, one byte, lsb first
	function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
			input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] c;
		logic [BYTE_W-1:0] d;
		logic              mix;
		c = crc;
		d = b;
		for (int k = 0; k < BYTE_W; k++) begin
			mix = c[0] ^ d[0];
			c = {1'b0, c[BYTE_W-1:1]} ^ (mix ? CRC_POLY : '0);
			d = {1'b0, d[BYTE_W-1:1]};
		end
		return c;
	endfunction

endpackage

@@ sv/tsd_if.sv @@
// interfaces: scratchpad byte stream, decoded result stream, register writes
interface tsd_item_if;
	logic       valid;
	logic       ready;
	logic       frame_start;
	logic [7:0] scratch_byte;
	logic [7:0] family_code;

	modport source (output valid, frame_start, scratch_byte, family_code, input ready);
	modport sink   (input valid, frame_start, scratch_byte, family_code, output ready);
endinterface

interface tsd_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] temp_sixteenths;
	logic [1:0]         status;

	modport source (output valid, temp_sixteenths, status, input ready);
	modport sink   (input valid, temp_sixteenths, status, output ready);
endinterface

interface tsd_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/temp_scratchpad_decoder.sv @@
// top level: scratchpad byte intake, crc, held bytes and result register
//
// Usage:
//   item   - one scratchpad byte per request; frame_start marks byte 0, and
//            family_code is sampled with byte 0. Bytes 0 to 7 give no result.
//   result - one request per frame, made on byte 8: the temperature in 1/16
//            degree and a status (ok, bad crc, out of range, unknown family).
//            Bytes past 8 are dropped until the next frame_start.
//   cfg    - index 0 writes low_limit, index 1 high_limit (exclusive bounds);
//            other indexes are ignored. Always ready.
// Path: an accepted byte 8 goes from the input register through the crc/conversion
//   logic into the result register, and from there onto result.
// Throughput: one byte per cycle unless stalled; the crc step and conversion
//   each fit in the single logic stage between the input and result registers.
// Reset: clears the byte counter, crc, family and both pipeline valids; limits
//   return to -55.0 and 85.0 degrees. A byte without frame_start right after
//   reset counts as byte 0.
// Stall: while a result waits, non-result bytes keep flowing; a second result
//   holds in the input register, and only then does item ready drop.
module temp_scratchpad_decoder (
	input  logic         clk,
	input  logic         arst_n,
	tsd_item_if.sink     item,
	tsd_result_if.source result,
	tsd_cfg_if.sink      cfg
);
	import tsd_pkg::*;

	logic                     valid_s1;
	logic                     start_s1;
	logic [BYTE_W-1:0]        byte_s1;
	logic [BYTE_W-1:0]        family_s1;

	logic [POS_W-1:0]         cnt_q;
	logic [BYTE_W-1:0]        crc_q;
	logic [BYTE_W-1:0]        family_q;
	logic [BYTE_W-1:0]        held_q [8];
	logic signed [TEMP_W-1:0] low_limit_q;
	logic signed [TEMP_W-1:0] high_limit_q;

	logic                     out_valid_q;
	result_t                  out_q;

	logic [POS_W-1:0]         pos_s1;
	logic                     emit_s1;
	logic                     out_free;
	logic                     adv_s1;
	logic                     take_s1;
	result_t                  res;

	assign pos_s1   = start_s1 ? FIRST_POS : cnt_q;
	assign emit_s1  = valid_s1 && (pos_s1 == CRC_POS);
	assign out_free = !out_valid_q || result.ready;
	assign adv_s1   = !emit_s1 || out_free;
	assign take_s1  = valid_s1 && adv_s1;

	assign item.ready = !valid_s1 || adv_s1;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q  <= LOW_LIMIT_RESET;
			high_limit_q <= HIGH_LIMIT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_LOW_LIMIT:  low_limit_q  <= cfg.data;
				CFG_HIGH_LIMIT: high_limit_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			start_s1  <= item.frame_start;
			byte_s1   <= item.scratch_byte;
			family_s1 <= item.family_code;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= FIRST_POS;
			crc_q    <= '0;
			family_q <= '0;
		end else if (take_s1) begin
			if (pos_s1 < CRC_POS) begin
				if (pos_s1 == FIRST_POS) begin
					crc_q    <= crc8_feed('0, byte_s1);
					family_q <= family_s1;
				end else begin
					crc_q <= crc8_feed(crc_q, byte_s1);
				end
				cnt_q <= pos_s1 + 4'd1;
			end else if (pos_s1 == CRC_POS) begin
				cnt_q <= DONE_POS;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && (pos_s1 < CRC_POS))
			held_q[pos_s1[2:0]] <= byte_s1;
	end

	tsd_convert u_convert (
		.family     (family_q),
		.crc        (crc_q),
		.crc_byte   (byte_s1),
		.byte0      (held_q[0]),
		.byte1      (held_q[1]),
		.byte4      (held_q[4]),
		.byte6      (held_q[6]),
		.byte7      (held_q[7]),
		.low_limit  (low_limit_q),
		.high_limit (high_limit_q),
		.res        (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit_s1)
			out_q <= res;
	end

	assign result.valid           = out_valid_q;
	assign result.temp_sixteenths = out_q.temp;
	assign result.status          = out_q.status;

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DONE_POS)
		else $error("byte counter past done position");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(emit_s1))
		else $error("result without a crc byte");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (emit_s1 && out_valid_q))
		else $error("item stalled without a pending result");

	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.status != ST_OK)) |-> (out_q.temp == '0))
		else $error("nonzero temperature with error status");

	a_count_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_s1 && adv_s1) |=> (cnt_q == DONE_POS))
		else $error("counter not parked after result");
`endif

endmodule

@@ sv/tsd_convert.sv @@
// reading conversion, family check, crc compare and range check
module tsd_convert (
	input  logic [tsd_pkg::BYTE_W-1:0]        family,
	input  logic [tsd_pkg::BYTE_W-1:0]        crc,
	input  logic [tsd_pkg::BYTE_W-1:0]        crc_byte,
	input  logic [tsd_pkg::BYTE_W-1:0]        byte0,
	input  logic [tsd_pkg::BYTE_W-1:0]        byte1,
	input  logic [tsd_pkg::BYTE_W-1:0]        byte4,
	input  logic [tsd_pkg::BYTE_W-1:0]        byte6,
	input  logic [tsd_pkg::BYTE_W-1:0]        byte7,
	input  logic signed [tsd_pkg::TEMP_W-1:0] low_limit,
	input  logic signed [tsd_pkg::TEMP_W-1:0] high_limit,
	output tsd_pkg::result_t                  res
);
	import tsd_pkg::*;

	logic [TEMP_W-1:0]        raw;
	logic [TEMP_W-1:0]        shifted;
	logic [TEMP_W-1:0]        reading;
	logic signed [TEMP_W-1:0] reading_s;
	logic                     known_family;
	logic [BYTE_W-1:0]        res_bits;

	assign raw          = {byte1, byte0};
	assign shifted      = {raw[TEMP_W-4:0], 3'b000};
	assign known_family = (family == FAM_9BIT) || (family == FAM_12BIT) ||
		(family == FAM_ALT);
	assign res_bits     = byte4 & RES_FIELD;

	always_comb begin
		if (family == FAM_9BIT) begin
			if (byte7 == COUNT_PER_C)
				reading = (shifted & HALF_MASK) + COUNT_BIAS - {8'h00, byte6};
			else
				reading = shifted;
		end else begin
			// undefined low bits depend on the resolution setting
			case (res_bits)
				RES_9BIT:  reading = raw & 16'hFFF8;
				RES_10BIT: reading = raw & 16'hFFFC;
				RES_11BIT: reading = raw & 16'hFFFE;
				default:   reading = raw;
			endcase
		end
	end

	assign reading_s = reading;

	always_comb begin
		res.temp = '0;
		if (!known_family) begin
			res.status = ST_FAMILY;
		end else if (crc != crc_byte) begin
			res.status = ST_BAD_CRC;
		end else if ((reading_s > low_limit) && (reading_s < high_limit)) begin
			res.status = ST_OK;
			res.temp   = reading_s;
		end else begin
			res.status = ST_RANGE;
		end
	end

endmodule

@@ verif/tsd_result_checker.sv @@
// checker: decodes every accepted scratchpad byte itself and compares the readings that come out
module tsd_result_checker (
	input  logic  clk,
	input  logic  arst_n,
	tsd_item_if   item,
	tsd_result_if result,
	tsd_cfg_if    cfg,
	output int    fails,
	output int    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import tsd_pkg::*;

	logic [POS_W-1:0]         byte_pos;
	logic [BYTE_W-1:0]        crc_acc;
	logic [BYTE_W-1:0]        frame_bytes [0:7];
	logic [BYTE_W-1:0]        frame_family;
	logic signed [TEMP_W-1:0] lim_lo;
	logic signed [TEMP_W-1:0] lim_hi;
	result_t                  expected_readings [$];
	int                       err_cnt;

	function automatic logic [BYTE_W-1:0] crc_step(input logic [BYTE_W-1:0] acc,
			input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		c = acc;
		// lsb first, polynomial folded in on a one shifted out
		for (int i = 0; i < BYTE_W; i++)
			c = (c[0] ^ data[i]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	task automatic count_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%s", msg);
	endtask

	task automatic decode_byte(input logic start, input logic [BYTE_W-1:0] b,
			input logic [BYTE_W-1:0] fam);
		logic [POS_W-1:0]  pos;
		logic [TEMP_W-1:0] word;
		status_t           st;
		result_t           want;
		pos = start ? FIRST_POS : byte_pos;
		if (pos < CRC_POS) begin
			if (pos == FIRST_POS) begin
				crc_acc = '0;
				frame_family = fam;
			end
			frame_bytes[pos[2:0]] = b;
			crc_acc = crc_step(crc_acc, b);
			byte_pos = pos + 1'b1;
		end else if (pos == CRC_POS) begin
			byte_pos = DONE_POS;
			word = {frame_bytes[1], frame_bytes[0]};
			if (frame_family != FAM_9BIT && frame_family != FAM_12BIT
					&& frame_family != FAM_ALT) begin
				st = ST_FAMILY;
			end else if (crc_acc != b) begin
				st = ST_BAD_CRC;
			end else begin
				if (frame_family == FAM_9BIT) begin
					word = word << 3;
					if (frame_bytes[7] == COUNT_PER_C)
						word = (word & HALF_MASK) + COUNT_BIAS - {8'h00, frame_bytes[6]};
				end else begin
					// low bits left undefined by the resolution setting are cleared
					case (frame_bytes[4] & RES_FIELD)
						RES_9BIT:  word = word & 16'hFFF8;
						RES_10BIT: word = word & 16'hFFFC;
						RES_11BIT: word = word & 16'hFFFE;
						default: ;
					endcase
				end
				st = ($signed(word) > lim_lo && $signed(word) < lim_hi) ? ST_OK : ST_RANGE;
			end
			want.temp = (st == ST_OK) ? word : '0;
			want.status = st;
			expected_readings.push_back(want);
		end
	endtask

	task automatic check_reading();
		result_t want;
		if (expected_readings.size() == 0) begin
			count_error($sformatf("unexpected reading: temp %0d status %0d",
				result.temp_sixteenths, result.status));
		end else begin
			want = expected_readings.pop_front();
			if (want.temp !== result.temp_sixteenths || want.status !== result.status)
				count_error($sformatf(
					"reading mismatch: expected temp %0d status %0d, got temp %0d status %0d",
					want.temp, want.status, result.temp_sixteenths, result.status));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos = FIRST_POS;
			crc_acc = '0;
			frame_family = '0;
			lim_lo = LOW_LIMIT_RESET;
			lim_hi = HIGH_LIMIT_RESET;
			expected_readings.delete();
			err_cnt = 0;
			fails <= 0;
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_LOW_LIMIT)
					lim_lo = cfg.data;
				else if (cfg.index == CFG_HIGH_LIMIT)
					lim_hi = cfg.data;
			end
			// the reading leaving now is always older than a byte 8 arriving now
			if (result.valid && result.ready)
				check_reading();
			if (item.valid && item.ready)
				decode_byte(item.frame_start, item.scratch_byte, item.family_code);
			fails <= err_cnt;
			pending <= expected_readings.size();
		end
	end

endmodule

@@ verif/temp_scratchpad_decoder_test.sv @@
// testbench top: scratchpad frame stimulus, limit settings, flow control and verdict
module temp_scratchpad_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tsd_pkg::*;

	logic clk;
	logic arst_n;

	tsd_item_if   item_ch ();
	tsd_result_if result_ch ();
	tsd_cfg_if    cfg_ch ();

	int fails;
	int pending;
	int sent;
	int tx_idle = 11;
	int rx_idle = 51;
	logic stall_req = 1'b0;

	logic [BYTE_W-1:0]        fb [0:8];
	logic signed [TEMP_W-1:0] cur_lo;
	logic signed [TEMP_W-1:0] cur_hi;

	temp_scratchpad_decoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	tsd_result_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.cfg     (cfg_ch),
		.fails   (fails),
		.pending (pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic logic [BYTE_W-1:0] frame_crc();
		logic [BYTE_W-1:0] c;
		c = '0;
		for (int n = 0; n < 8; n++)
			for (int i = 0; i < BYTE_W; i++)
				c = (c[0] ^ fb[n][i]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	task automatic send_byte(input logic start, input logic [BYTE_W-1:0] b,
			input logic [BYTE_W-1:0] fam);
		while ($urandom_range(99) < tx_idle) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.frame_start <= start;
		item_ch.scratch_byte <= b;
		item_ch.family_code <= fam;
		do @(posedge clk); while (!item_ch.ready);
		sent++;
	endtask

	task automatic send_frame(input logic mark, input logic [BYTE_W-1:0] fam,
			input int upto, input int extras);
		for (int n = 0; n < upto; n++)
			send_byte((n == 0) ? mark : 1'b0, fb[n], (n == 0) ? fam : 8'($urandom_range(255)));
		for (int n = 0; n < extras; n++)
			send_byte(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [TEMP_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic set_limits(input logic signed [TEMP_W-1:0] lo,
			input logic signed [TEMP_W-1:0] hi);
		write_reg(CFG_LOW_LIMIT, lo);
		write_reg(CFG_HIGH_LIMIT, hi);
		// an unused index must leave both limits alone
		write_reg(4'($urandom_range(15, 2)), 16'($urandom));
		cfg_ch.valid <= 1'b0;
		cur_lo = lo;
		cur_hi = hi;
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic random_frame();
		int                pick;
		logic [BYTE_W-1:0] fam;
		logic [TEMP_W-1:0] t;
		logic [TEMP_W-1:0] bound;
		pick = $urandom_range(99);
		if (pick < 35)
			fam = FAM_9BIT;
		else if (pick < 65)
			fam = FAM_12BIT;
		else if (pick < 90)
			fam = FAM_ALT;
		else
			fam = 8'($urandom_range(255));

		pick = $urandom_range(99);
		if (pick < 40) begin
			t = 16'(int'($urandom_range(2400)) - 1000);
		end else if (pick < 70) begin
			bound = $urandom_range(1) ? cur_lo : cur_hi;
			t = bound + 16'($urandom_range(16)) - 16'd8;
		end else begin
			t = 16'($urandom);
		end
		// the 9-bit format is shifted up by three, so aim it lower
		if (fam == FAM_9BIT && pick < 70)
			t = 16'($signed(t) >>> 3);

		fb[0] = t[7:0];
		fb[1] = t[15:8];
		for (int n = 2; n < 8; n++)
			fb[n] = 8'($urandom_range(255));
		if (fam == FAM_9BIT && $urandom_range(1)) begin
			fb[6] = 8'($urandom_range(16));
			fb[7] = COUNT_PER_C;
		end
		fb[8] = frame_crc();
		if ($urandom_range(99) < 10)
			fb[8] = fb[8] ^ 8'($urandom_range(255, 1));

		pick = $urandom_range(99);
		if (pick < 80) begin
			send_frame(1'b1, fam, 9, 0);
		end else if (pick < 87) begin
			send_frame(1'b1, fam, 9, $urandom_range(3, 1));
		end else if (pick < 93) begin
			// cut short, the next marker restarts the frame
			send_frame(1'b1, fam, $urandom_range(8, 1), 0);
		end else if (pick < 96) begin
			send_frame(1'b0, fam, 9, 0);
		end else begin
			repeat ($urandom_range(6, 1))
				send_byte(1'($urandom_range(1)), 8'($urandom_range(255)),
					8'($urandom_range(255)));
		end
	endtask

	// result side: random back-pressure plus one long hold-off
	initial begin
		bit held;
		held = 1'b0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_req && !held) begin
				held = 1'b1;
				result_ch.ready <= 1'b0;
				for (int k = 0; k < 300; k++)
					@(posedge clk);
			end else begin
				result_ch.ready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	initial begin
		int seg;
		int seg_end;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.frame_start = 1'b0;
		item_ch.scratch_byte = '0;
		item_ch.family_code = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		sent = 0;
		cur_lo = LOW_LIMIT_RESET;
		cur_hi = HIGH_LIMIT_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no marker after reset; count remain lands exactly on the upper bound
		fb[0] = 8'hAA;
		fb[1] = 8'h00;
		for (int n = 2; n < 6; n++)
			fb[n] = 8'h00;
		fb[6] = 8'h0C;
		fb[7] = COUNT_PER_C;
		fb[8] = frame_crc();
		send_frame(1'b0, FAM_9BIT, 9, 0);

		// all ones reads as -1/16 with full resolution, then a trailing byte
		for (int n = 0; n < 8; n++)
			fb[n] = 8'hFF;
		fb[8] = frame_crc();
		send_frame(1'b1, FAM_12BIT, 9, 1);

		// unknown family wins over a bad crc
		for (int n = 0; n < 8; n++)
			fb[n] = 8'h00;
		fb[8] = 8'hFF;
		send_frame(1'b1, 8'h00, 9, 0);

		for (seg = 0; seg < 6; seg++) begin
			drain();
			case (seg)
				0: set_limits(LOW_LIMIT_RESET, HIGH_LIMIT_RESET);
				1: set_limits(16'sh8000, 16'sh7FFF);
				2: set_limits(16'sd400, 16'sd400);
				3: set_limits(16'(-int'($urandom_range(1200))), 16'($urandom_range(2000)));
				4: set_limits(16'sh7FFF, 16'sh8000);
				default: set_limits(16'($urandom), 16'($urandom));
			endcase
			case (seg / 2)
				0: begin
					tx_idle = 11;
					rx_idle <= 51;
				end
				1: begin
					tx_idle = 51;
					rx_idle <= 11;
				end
				default: begin
					tx_idle = 0;
					rx_idle <= 0;
				end
			endcase
			if (seg == 5)
				stall_req <= 1'b1;
			seg_end = sent + 155;
			while (sent < seg_end)
				random_frame();
		end

		drain();
		if (fails == 0)
			$display("temp_scratchpad_decoder_test: done, clean");
		else
			$display("temp_scratchpad_decoder_test: done, errors");
		$finish;
	end

	initial begin
		#400000;
		$display("temp_scratchpad_decoder_test: done, errors");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/tsd_pkg.sv
sv/tsd_if.sv
sv/tsd_convert.sv
sv/temp_scratchpad_decoder.sv
verif/tsd_result_checker.sv
verif/temp_scratchpad_decoder_test.sv
